@@ sv/met_pkg.sv @@
// Shared types, constants and fixed-point helpers for the Mandelbrot
// escape-time block. No dependencies; used by every module of the block.
package met_pkg;

  // Number format: WIDTH-bit two's complement with FRAC_BITS fraction bits.
  localparam int unsigned WIDTH     = 32;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned IN_W      = 32;
  localparam int unsigned CNT_W     = 16;

  typedef logic signed [WIDTH-1:0]   fix_t;
  typedef logic signed [2*WIDTH-1:0] prod_t;
  typedef logic signed [IN_W-1:0]    in_t;
  typedef logic        [CNT_W-1:0]   cnt_t;

  // The escape radius squared, 4.0, wrapped to the number format.
  localparam fix_t FOUR = fix_t'(64'd4 << FRAC_BITS);

  // Reset value of the iteration limit.
  localparam cnt_t MAX_ITER_RESET = cnt_t'(256);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // Capture c and clear z.
    logic mul_en;  // Register the three products of the current z.
    logic upd_en;  // Replace z with z*z + c.
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic escaped;  // |z|^2 of the current z is above four.
  } sts_t;

  // Sign-extend or wrap an input value into the number format.
  function automatic fix_t to_fix(input in_t v);
    return fix_t'(v);
  endfunction

  // Fixed-point multiply: full signed product, arithmetic shift, wrap.
  function automatic fix_t fx_mul(input fix_t a, input fix_t b);
    prod_t p;
    p = prod_t'(a) * prod_t'(b);
    return p[FRAC_BITS +: WIDTH];
  endfunction

endpackage

@@ sv/met_datapath.sv @@
// Datapath of the escape-time block: z registers, c registers, the three
// product registers and the escape compare. Depends on met_pkg.
module met_datapath (
  input  logic           clk_i,
  input  met_pkg::in_t   c_real_i,
  input  met_pkg::in_t   c_imag_i,
  input  met_pkg::cmd_t  cmd_i,
  output met_pkg::sts_t  sts_o
);

  met_pkg::fix_t cr_q, ci_q;
  met_pkg::fix_t x_q, x_d, y_q, y_d;
  met_pkg::fix_t p_xx_q, p_yy_q, p_xy_q;
  met_pkg::fix_t mag;

  // Next z from the registered products: x^2 - y^2 + cr and 2xy + ci.
  // Multiplying by fixed-point two is an exact left shift by one.
  always_comb begin
    x_d = p_xx_q - p_yy_q + cr_q;
    y_d = (p_xy_q <<< 1) + ci_q;
  end

  // Payload registers need no reset; the controller loads them first.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cr_q <= met_pkg::to_fix(c_real_i);
      ci_q <= met_pkg::to_fix(c_imag_i);
      x_q  <= '0;
      y_q  <= '0;
    end else if (cmd_i.upd_en) begin
      x_q <= x_d;
      y_q <= y_d;
    end
    if (cmd_i.mul_en) begin
      p_xx_q <= met_pkg::fx_mul(x_q, x_q);
      p_yy_q <= met_pkg::fx_mul(y_q, y_q);
      p_xy_q <= met_pkg::fx_mul(x_q, y_q);
    end
  end

  // Squared magnitude of the current z, compared signed against four.
  assign mag           = p_xx_q + p_yy_q;
  assign sts_o.escaped = (mag > met_pkg::FOUR);

endmodule

@@ sv/met_ctrl.sv @@
// Controller of the escape-time block: iteration limit register, state
// machine, iteration counter and the result register. Depends on met_pkg.
module met_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           max_iterations_we_i,
  input  met_pkg::cnt_t  max_iterations_i,
  input  met_pkg::sts_t  sts_i,
  output met_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           done_o,
  output met_pkg::cnt_t  escape_count_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_STEP
  } state_e;

  state_e        state_q;
  met_pkg::cnt_t max_q;
  met_pkg::cnt_t cnt_q;
  met_pkg::cnt_t result_q;
  logic          done_q;
  logic          accept;
  logic          hit;
  logic          last;
  logic          finish;

  assign accept = start_i && (state_q == ST_IDLE);

  // After the first update, z of the current count either escapes, or the
  // next count would reach the limit; either way the transaction ends.
  always_comb begin
    hit    = (cnt_q != '0) && sts_i.escaped;
    last   = (cnt_q != '0) &&
             (({1'b0, cnt_q} + {{met_pkg::CNT_W{1'b0}}, 1'b1}) >= {1'b0, max_q});
    finish = hit || last;
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o.load   = accept;
    cmd_o.mul_en = (state_q == ST_MUL);
    cmd_o.upd_en = (state_q == ST_STEP) && !finish;
  end

  // State, counter, limit register and registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      max_q    <= met_pkg::MAX_ITER_RESET;
      cnt_q    <= '0;
      result_q <= '0;
      done_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (max_iterations_we_i) begin
        max_q <= max_iterations_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cnt_q <= '0;
            if (max_q <= met_pkg::cnt_t'(1)) begin
              // A limit of zero or one tries no count at all.
              done_q   <= 1'b1;
              result_q <= '0;
            end else begin
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          state_q <= ST_STEP;
        end
        ST_STEP: begin
          if (finish) begin
            done_q   <= 1'b1;
            result_q <= hit ? cnt_q : '0;
            state_q  <= ST_IDLE;
          end else begin
            cnt_q   <= cnt_q + met_pkg::cnt_t'(1);
            state_q <= ST_MUL;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign escape_count_o = result_q;

endmodule

@@ sv/mandelbrot_escape_time_fixed.sv @@
// Top level of the fixed-point Mandelbrot escape-time block.
// Depends on met_pkg, met_ctrl and met_datapath.
//
//   channel   ports                                     direction
//   command   start_i, busy_o, c_real_i, c_imag_i       in
//   result    done_o, escape_count_o                    out
//   config    max_iterations_we_i, max_iterations_i     in
//
// A transaction is accepted when start_i is high and busy_o is low.
// Each count registers the three 32x32 products of z (ST_MUL), then forms
// the next z and tests |z|^2 (ST_STEP). busy_o stays high until the point
// escapes or the iteration limit is reached; done_o pulses in the first idle cycle after that,
// or in the cycle after acceptance for a limit of zero or one, which never goes busy.
// Reset is asynchronous and active low; the limit resets to 256. The receiver cannot stall.
module mandelbrot_escape_time_fixed (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  logic [31:0]   c_real_i,
  input  logic [31:0]   c_imag_i,
  output logic          done_o,
  output logic [15:0]   escape_count_o,
  input  logic          max_iterations_we_i,
  input  logic [15:0]   max_iterations_i
);

  met_pkg::cmd_t cmd;
  met_pkg::sts_t sts;

  met_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start_i             (start_i),
    .max_iterations_we_i (max_iterations_we_i),
    .max_iterations_i    (max_iterations_i),
    .sts_i               (sts),
    .cmd_o               (cmd),
    .busy_o              (busy_o),
    .done_o              (done_o),
    .escape_count_o      (escape_count_o)
  );

  met_datapath u_datapath (
    .clk_i    (clk_i),
    .c_real_i (c_real_i),
    .c_imag_i (c_imag_i),
    .cmd_i    (cmd),
    .sts_o    (sts)
  );

endmodule

@@ sv/met_checker.sv @@
// Port-level checks of the escape-time block's transaction sequencing,
// bound to mandelbrot_escape_time_fixed. No package dependency.
module met_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [15:0] escape_count_o
);

  // An accepted transaction either starts work or answers at once.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o || done_o)
    else $error("accepted transaction neither started nor answered");

  // The block becomes idle only by delivering a result.
  a_busy_fall_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  // A result is shown only while the block is idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // Every result follows work or a just-accepted transaction.
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o) || $past(start_i && !busy_o))
    else $error("result without a transaction");

  // A strobed result always carries a defined count.
  a_count_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$isunknown(escape_count_o))
    else $error("result count is unknown");

endmodule

bind mandelbrot_escape_time_fixed met_checker u_met_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .escape_count_o (escape_count_o)
);
